### rtl/core/lirs_pkg.sv
package lirs_pkg;

  localparam int CH_IN_W     = 3;
  localparam int SAMPLE_W    = 32;
  localparam int INC_W       = 21;
  localparam int FMT_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FORMAT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT   = 2'd2;

  localparam logic [INC_W-1:0] INC_RESET  = 21'd65536;
  localparam logic [FMT_W-1:0] IFMT_RESET = 2'd1;
  localparam logic [FMT_W-1:0] OFMT_RESET = 2'd0;

  typedef enum logic [FMT_W-1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2
  } fmt_t;

  localparam logic [FMT_W-1:0] OFMT_SAME = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RSVD  = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic emit;
    logic store;
  } lirs_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic ph_lt_one;
    logic last;
    logic out_free;
  } lirs_stat_t;

endpackage

### rtl/core/lirs_in_if.sv
interface lirs_in_if import lirs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_IN_W-1:0]         channel;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

### rtl/core/lirs_out_if.sv
interface lirs_out_if import lirs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_IN_W-1:0]         out_channel;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_of_run;

  modport source (output valid, output out_channel, output sample_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_channel, input sample_out, input last_of_run,
                  output ready);
endinterface

### rtl/core/lirs_cfg_if.sv
interface lirs_cfg_if import lirs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/lirs_cfg.sv
module lirs_cfg import lirs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  wr_ready,
  output logic [FRAC_BITS+4:0]  inc_eff,
  output fmt_t                  ifmt,
  output fmt_t                  ofmt
);

  localparam int PH_W = FRAC_BITS + 5;
  localparam logic [31:0] INC_MIN = 32'd1 << (FRAC_BITS - 3);
  localparam logic [31:0] INC_MAX = 32'd1 << (FRAC_BITS + 4);

  logic [INC_W-1:0] inc_r;
  logic [FMT_W-1:0] ifmt_r;
  logic [FMT_W-1:0] ofmt_r;
  logic [31:0]      inc_wide;
  logic [31:0]      inc_sel;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= INC_RESET;
      ifmt_r <= IFMT_RESET;
      ofmt_r <= OFMT_RESET;
    end else if (wr_valid) begin
      case (wr_index)
        CFG_PHASE_INCREMENT: inc_r  <= wr_data[INC_W-1:0];
        CFG_INPUT_FORMAT:    ifmt_r <= wr_data[FMT_W-1:0];
        CFG_OUTPUT_FORMAT:   ofmt_r <= wr_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the increment to one eighth .. sixteen
  always_comb begin
    inc_wide = {{(32-INC_W){1'b0}}, inc_r};
    if (inc_wide < INC_MIN) begin
      inc_sel = INC_MIN;
    end else if (inc_wide > INC_MAX) begin
      inc_sel = INC_MAX;
    end else begin
      inc_sel = inc_wide;
    end
  end

  assign inc_eff = inc_sel[PH_W-1:0];

  always_comb begin
    ifmt = (ifmt_r == FMT_RSVD) ? FMT_S32 : fmt_t'(ifmt_r);
    if (ofmt_r == OFMT_SAME || ofmt_r == FMT_RSVD) begin
      ofmt = ifmt;
    end else begin
      ofmt = fmt_t'(ofmt_r);
    end
  end

endmodule

### rtl/core/lirs_ctrl.sv
module lirs_ctrl import lirs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lirs_stat_t stat,
  output lirs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_EMIT,
    S_STORE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = 1'b0;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        in_ready_nxt = 1'b1;
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          state_nxt    = S_CHECK;
          in_ready_nxt = 1'b0;
        end
      end
      S_CHECK: begin
        if (!stat.ch_ok) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end else if (stat.ph_lt_one) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? S_STORE : S_MUL;
        end
      end
      S_STORE: begin
        cmd.store    = 1'b1;
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("emit issued while output register occupied");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready_r) |=> !in_ready_r)
    else $error("input still open after accepting a beat");

  a_store_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> in_ready_r)
    else $error("input not reopened after write-back");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !stat.last) |=> cmd.mul)
    else $error("run stopped before its last beat");

endmodule

### rtl/core/lirs_dp.sv
module lirs_dp import lirs_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [CH_IN_W-1:0]         in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [FRAC_BITS+4:0]       inc_eff,
  input  fmt_t                       ifmt,
  input  fmt_t                       ofmt,
  input  lirs_cmd_t                  cmd,
  output lirs_stat_t                 stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CH_IN_W-1:0]         out_channel,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last
);

  localparam int PH_W   = FRAC_BITS + 5;
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam logic [PH_W-1:0] ONE_Q = {{(PH_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [SAMPLE_W-1:0] prev_mem [NUM_CHANNELS];
  logic [PH_W-1:0]            phase_mem [NUM_CHANNELS];

  logic [CH_IN_W-1:0]         ch_r;
  logic [CH_W-1:0]            idx_r;
  logic                       ch_ok_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic [PH_W-1:0]            ph_r;
  logic [CNT_W-1:0]           n_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r;
  logic [CH_IN_W-1:0]         out_ch_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic                       in_ok;
  logic [CH_W-1:0]            in_idx;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_BITS:0]  t_s;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    quot;
  logic [NUM_W-1:0]           val;
  logic                       round_up;
  logic [PH_W-1:0]            ph_nxt;

  function automatic logic signed [SAMPLE_W-1:0] convert(
    input logic signed [SAMPLE_W-1:0] raw,
    input fmt_t                       fi,
    input fmt_t                       fo
  );
    logic [7:0]         s8;
    logic [15:0]        v16;
    logic signed [32:0] biased;
    logic signed [16:0] r17;
    logic signed [SAMPLE_W-1:0] res;
    s8     = {~raw[7], raw[6:0]};
    v16    = raw[15:0];
    biased = {raw[31], raw} + 33'sd32768;
    r17    = biased[32:16];
    res    = raw;
    case (fi)
      FMT_U8: begin
        if (fo == FMT_S16) begin
          res = {{16{s8[7]}}, s8, 8'h00};
        end else if (fo == FMT_S32) begin
          res = {s8, 24'h000000};
        end else begin
          res = {24'h000000, raw[7:0]};
        end
      end
      FMT_S16: begin
        if (fo == FMT_S32) begin
          res = {v16, 16'h0000};
        end else begin
          res = {{16{v16[15]}}, v16};
        end
      end
      default: begin
        if (fo == FMT_S16) begin
          if (r17 > 17'sd32767) begin
            res = 32'sd32767;
          end else begin
            res = {{15{r17[16]}}, r17};
          end
        end else begin
          res = raw;
        end
      end
    endcase
    return res;
  endfunction

  assign in_ok  = ({{(32-CH_IN_W){1'b0}}, in_channel} < NUM_CHANNELS);
  assign in_idx = CH_W'(in_channel);

  assign diff = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign t_s  = $signed({1'b0, ph_r[FRAC_BITS-1:0]});

  // value = (prev * one + (cur - prev) * t) / one, toward zero
  always_comb begin
    num      = (NUM_W'(prev_r) <<< FRAC_BITS) + NUM_W'(prod_r);
    quot     = num >>> FRAC_BITS;
    round_up = num[NUM_W-1] && (num[FRAC_BITS-1:0] != '0);
    val      = quot + {{(NUM_W-1){1'b0}}, round_up};
  end

  assign ph_nxt = ph_r + inc_eff;

  assign stat.ch_ok     = ch_ok_r;
  assign stat.ph_lt_one = (ph_r < ONE_Q);
  assign stat.last      = (ph_nxt >= ONE_Q) || (n_r == CNT_W'(MAX_RESULTS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r    <= in_channel;
      idx_r   <= in_idx;
      cur_r   <= convert(in_sample, ifmt, ofmt);
      prev_r  <= in_ok ? prev_mem[in_idx] : '0;
      ph_r    <= in_ok ? phase_mem[in_idx] : '0;
      n_r     <= '0;
    end else if (cmd.emit) begin
      ph_r    <= ph_nxt;
      n_r     <= n_r + CNT_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff) * PROD_W'(t_s);
    end
    if (cmd.emit) begin
      out_ch_r     <= ch_r;
      out_sample_r <= val[SAMPLE_W-1:0];
      out_last_r   <= stat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_ok_r <= 1'b0;
    end else if (cmd.load) begin
      ch_ok_r <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_mem[i]  <= '0;
        phase_mem[i] <= '0;
      end
    end else if (cmd.store && ch_ok_r) begin
      prev_mem[idx_r]  <= cur_r;
      phase_mem[idx_r] <= ph_r - ONE_Q;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_sample  = out_sample_r;
  assign out_last    = out_last_r;

endmodule

### rtl/core/linear_interp_resampler.sv
// Linear-interpolation resampler, one sample beat in, zero to eight beats out.
// Each item is loaded and checked, then the controller loop runs a multiply step
// and an emit step per result on one shared multiplier, then a write-back; an
// unused channel returns to idle after the check. Output stalls hold the loop.
// Synchronous active-low reset clears phases, stored samples, config and control state.
module linear_interp_resampler import lirs_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lirs_in_if.sink     in_bus,
  lirs_out_if.source  out_bus,
  lirs_cfg_if.sink    cfg_bus
);

  logic [FRAC_BITS+4:0] inc_eff;
  fmt_t                 ifmt;
  fmt_t                 ofmt;
  lirs_cmd_t            cmd;
  lirs_stat_t           stat;

  lirs_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .wr_ready (cfg_bus.ready),
    .inc_eff  (inc_eff),
    .ifmt     (ifmt),
    .ofmt     (ofmt)
  );

  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lirs_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_channel  (in_bus.channel),
    .in_sample   (in_bus.sample_in),
    .inc_eff     (inc_eff),
    .ifmt        (ifmt),
    .ofmt        (ofmt),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_channel (out_bus.out_channel),
    .out_sample  (out_bus.sample_out),
    .out_last    (out_bus.last_of_run)
  );

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lirs_pkg::*;

  localparam int     FRAC          = 16;
  localparam int     NCH           = 8;
  localparam longint ONE           = longint'(1) << FRAC;
  localparam longint INC_FLOOR     = ONE >> 3;
  localparam longint INC_CEIL      = ONE << 4;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     LIMIT         = 600000;
  localparam int     RANDOM_ITEMS  = 358;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {JOB_SAMPLE, JOB_WRITE, JOB_SETTLE} job_kind_t;

  typedef struct {
    job_kind_t              kind;
    logic [CH_IN_W-1:0]     ch;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    int                     gap;
  } job_t;

  typedef struct packed {
    logic [CH_IN_W-1:0]  ch;
    logic [SAMPLE_W-1:0] smp;
    logic                last;
  } interp_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lirs_in_if  in_bus ();
  lirs_out_if out_bus ();
  lirs_cfg_if cfg_bus ();

  linear_interp_resampler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  job_t         job_q[$];
  interp_beat_t owed_q[$];

  logic [INC_W-1:0]           inc_reg;
  logic [FMT_W-1:0]           ifmt_reg;
  logic [FMT_W-1:0]           ofmt_reg;
  logic signed [SAMPLE_W-1:0] prev_smp [NCH];
  logic [INC_W-1:0]           phase_acc [NCH];

  int errors     = 0;
  int n_in       = 0;
  int n_out      = 0;
  int n_cfg      = 0;
  int n_silent   = 0;
  int n_settings = 0;
  int cycle_cnt  = 0;
  int gap_left   = 0;
  int quiet      = 0;
  int hold_left  = 0;
  bit burst_seg  = 1'b0;
  bit in_fire    = 1'b0;
  bit cfg_fire   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] to_out_format(input logic [SAMPLE_W-1:0] raw,
                                                                input fmt_t ifmt,
                                                                input logic [FMT_W-1:0] ofmt);
    longint v;
    case (ifmt)
      FMT_U8: begin
        v = longint'(raw[7:0]) - 128;
        if (ofmt == FMT_S16) return SAMPLE_W'(v <<< 8);
        if (ofmt == FMT_S32) return SAMPLE_W'(v <<< 24);
        return {24'b0, raw[7:0]};
      end
      FMT_S16: begin
        if (ofmt == FMT_S32) return {raw[15:0], 16'h0000};
        return {{16{raw[15]}}, raw[15:0]};
      end
      default: begin
        if (ofmt != FMT_S16) return raw;
        v = (longint'($signed(raw)) + 32768) >>> 16;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  task automatic resample_step(input logic [CH_IN_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
    fmt_t                       ifmt;
    logic [FMT_W-1:0]           ofmt;
    longint                     inc;
    longint                     ph;
    longint                     num;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] prv;
    interp_beat_t               b;
    int                         n;
    ifmt = (ifmt_reg == FMT_RSVD) ? FMT_S32 : fmt_t'(ifmt_reg);
    ofmt = (ofmt_reg == OFMT_SAME || ofmt_reg == FMT_RSVD) ? ifmt : ofmt_reg;
    inc = longint'(inc_reg);
    if (inc < INC_FLOOR) inc = INC_FLOOR;
    if (inc > INC_CEIL) inc = INC_CEIL;
    cur = to_out_format(raw, ifmt, ofmt);
    prv = prev_smp[ch];
    ph = longint'(phase_acc[ch]);
    n = 0;
    while (ph < ONE && n < MAX_RESULTS) begin
      num = longint'(prv) * (ONE - ph) + longint'(cur) * ph;
      b.ch = ch;
      b.smp = SAMPLE_W'(num / ONE);
      b.last = (ph + inc >= ONE) || (n == MAX_RESULTS - 1);
      owed_q.push_back(b);
      n++;
      ph += inc;
    end
    if (n == 0) n_silent++;
    phase_acc[ch] = INC_W'(ph - ONE);
    prev_smp[ch] = cur;
  endtask

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic push_sample(input logic [CH_IN_W-1:0] ch, input logic [SAMPLE_W-1:0] v);
    job_t j;
    int   r;
    r = $urandom_range(0, 99);
    j.kind = JOB_SAMPLE;
    j.ch = ch;
    j.idx = CFG_PHASE_INCREMENT;
    j.value = v;
    if (burst_seg || r < 55) j.gap = 0;
    else if (r < 85) j.gap = $urandom_range(1, 3);
    else if (r < 97) j.gap = $urandom_range(4, 12);
    else j.gap = $urandom_range(20, 40);
    job_q.push_back(j);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    job_t j;
    j.kind = JOB_WRITE;
    j.ch = '0;
    j.idx = idx;
    j.value = v;
    j.gap = 0;
    job_q.push_back(j);
  endtask

  task automatic push_settle();
    job_t j;
    j.kind = JOB_SETTLE;
    j.ch = '0;
    j.idx = CFG_PHASE_INCREMENT;
    j.value = '0;
    j.gap = 0;
    job_q.push_back(j);
  endtask

  task automatic push_setting(input logic [INC_W-1:0] inc, input logic [FMT_W-1:0] ifmt,
                              input logic [FMT_W-1:0] ofmt);
    n_settings++;
    push_settle();
    push_write(CFG_PHASE_INCREMENT, {11'($urandom), inc});
    push_write(CFG_INPUT_FORMAT, {30'($urandom), ifmt});
    push_write(CFG_OUTPUT_FORMAT, {30'($urandom), ofmt});
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [FMT_W-1:0] ifmt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 35) begin
      case ($urandom_range(0, 7))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_7FFF;
        3: return 32'hFFFF_8000;
        4: return 32'h0000_00FF;
        5: return 32'h0000_8000;
        6: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    if (ifmt == FMT_U8) return $urandom_range(0, 255);
    if (ifmt == FMT_S16) return {{16{r[0]}}, 16'($urandom)} ^ {16'h0, {16{r[0]}} & 16'h8000};
    return $urandom;
  endfunction

  // drive sample and register beats from the job queue
  always @(negedge clk) begin
    job_t job;
    logic nxt_in;
    logic nxt_cfg;
    if (rst_n && !(in_bus.valid && !in_fire) && !(cfg_bus.valid && !cfg_fire)) begin
      nxt_in = 1'b0;
      nxt_cfg = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (job_q.size() > 0) begin
        job = job_q[0];
        case (job.kind)
          JOB_SAMPLE: begin
            in_bus.channel <= job.ch;
            in_bus.sample_in <= job.value;
            nxt_in = 1'b1;
            gap_left = job.gap;
            job = job_q.pop_front();
          end
          JOB_WRITE: begin
            cfg_bus.index <= job.idx;
            cfg_bus.data <= job.value;
            nxt_cfg = 1'b1;
            job = job_q.pop_front();
          end
          default: begin
            if (owed_q.size() != 0) begin
              quiet = 0;
            end else if (quiet < SETTLE_CYCLES) begin
              quiet++;
            end else begin
              quiet = 0;
              job = job_q.pop_front();
            end
          end
        endcase
      end
      in_bus.valid <= nxt_in;
      cfg_bus.valid <= nxt_cfg;
    end
  end

  // result-side back-pressure: short stalls, a few long ones, stretches of none
  always @(negedge clk) begin
    int r;
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        out_bus.ready <= 1'b1;
        hold_left = $urandom_range(0, 7);
      end else if (r < 15) begin
        out_bus.ready <= 1'b1;
        hold_left = $urandom_range(30, 120);
      end else if (r < 19) begin
        out_bus.ready <= 1'b0;
        hold_left = $urandom_range(0, 2);
      end else begin
        out_bus.ready <= 1'b0;
        hold_left = $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk) begin
    interp_beat_t want;
    in_fire = rst_n && in_bus.valid && in_bus.ready;
    cfg_fire = rst_n && cfg_bus.valid && cfg_bus.ready;
    if (in_fire) begin
      n_in++;
      resample_step(in_bus.channel, in_bus.sample_in);
    end
    if (cfg_fire) begin
      n_cfg++;
      case (cfg_bus.index)
        CFG_PHASE_INCREMENT: inc_reg = cfg_bus.data[INC_W-1:0];
        CFG_INPUT_FORMAT:    ifmt_reg = cfg_bus.data[FMT_W-1:0];
        CFG_OUTPUT_FORMAT:   ofmt_reg = cfg_bus.data[FMT_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_out++;
      if (owed_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat ch %0d sample %0d last %0b",
                                out_bus.out_channel, out_bus.sample_out, out_bus.last_of_run));
      end else begin
        want = owed_q.pop_front();
        if (out_bus.out_channel !== want.ch)
          note_mismatch($sformatf("beat %0d out_channel expected %0d got %0d",
                                  n_out, want.ch, out_bus.out_channel));
        if (out_bus.sample_out !== want.smp)
          note_mismatch($sformatf("beat %0d sample_out expected %0d got %0d",
                                  n_out, $signed(want.smp), out_bus.sample_out));
        if (out_bus.last_of_run !== want.last)
          note_mismatch($sformatf("beat %0d last_of_run expected %0b got %0b",
                                  n_out, want.last, out_bus.last_of_run));
      end
    end
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_cnt, owed_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int                 n;
    int                 seg;
    int                 pick;
    int                 items;
    logic [CH_IN_W-1:0] focus;
    logic [CH_IN_W-1:0] ch;
    logic [INC_W-1:0]   inc;
    logic [FMT_W-1:0]   ifmt;
    logic [FMT_W-1:0]   ofmt;

    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.sample_in = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_PHASE_INCREMENT;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    inc_reg = INC_RESET;
    ifmt_reg = IFMT_RESET;
    ofmt_reg = OFMT_RESET;
    for (int c = 0; c < NCH; c++) begin
      prev_smp[c] = '0;
      phase_acc[c] = '0;
    end

    // reset settings: unit increment, s16 passed through
    push_sample(3'd0, 32'h0000_7FFF);
    push_sample(3'd0, 32'hFFFF_8000);
    push_sample(3'd7, 32'hDEAD_1234);
    push_sample(3'd7, 32'h0000_0000);
    push_setting(INC_W'(INC_FLOOR), FMT_U8, OFMT_SAME);
    push_sample(3'd3, 32'h0000_00FF);
    push_sample(3'd3, 32'h0000_0000);
    push_sample(3'd3, 32'hABCD_EF80);
    push_setting(21'd40000, FMT_U8, FMT_S16);
    push_sample(3'd1, 32'h0000_00FF);
    push_sample(3'd1, 32'h0000_0000);
    // switch format with stored samples left in place
    push_setting(21'd65536, FMT_U8, FMT_S32);
    push_sample(3'd1, 32'h0000_0080);
    push_sample(3'd1, 32'h0000_00FF);
    push_setting(21'd30000, FMT_S32, FMT_S16);
    push_sample(3'd2, 32'h7FFF_FFFF);
    push_sample(3'd2, 32'h8000_0000);
    push_sample(3'd2, 32'h0000_7FFF);
    push_sample(3'd2, 32'h0000_8000);
    // increment below the floor, then above the ceiling with reserved formats
    push_setting(21'd0, FMT_S16, FMT_S32);
    push_sample(3'd4, 32'h0000_8000);
    push_sample(3'd4, 32'h0000_7FFF);
    push_setting(21'h1F_FFFF, FMT_RSVD, FMT_RSVD);
    push_sample(3'd5, 32'h8000_0000);
    push_sample(3'd5, 32'h7FFF_FFFF);
    push_sample(3'd5, $urandom);
    push_setting(INC_W'(INC_CEIL), FMT_S16, FMT_S16);
    push_sample(3'd6, 32'h0000_1234);
    push_sample(3'd6, 32'hFFFF_EDCC);
    push_settle();
    push_write(CFG_UNUSED, 32'hFFFF_FFFF);

    n = 0;
    seg = 0;
    while (n < RANDOM_ITEMS) begin
      burst_seg = (seg % 3 == 2);
      pick = (seg < 4) ? seg : $urandom_range(0, 9);
      case (pick)
        0: inc = INC_W'(INC_FLOOR);
        1: inc = INC_W'(INC_CEIL);
        2: inc = INC_W'($urandom_range(0, int'(INC_FLOOR) - 1));
        3: inc = INC_W'($urandom_range(int'(INC_CEIL) + 1, (1 << INC_W) - 1));
        default: inc = INC_W'($urandom_range(int'(INC_FLOOR), int'(3 * ONE / 2)));
      endcase
      ifmt = FMT_W'($urandom_range(0, 3));
      ofmt = FMT_W'($urandom_range(0, 3));
      push_setting(inc, ifmt, ofmt);
      focus = CH_IN_W'($urandom_range(0, NCH - 1));
      items = $urandom_range(30, 60);
      if (items > RANDOM_ITEMS - n) items = RANDOM_ITEMS - n;
      repeat (items) begin
        if ($urandom_range(0, 49) == 0) push_settle();
        if ($urandom_range(0, 99) < 70) ch = focus + CH_IN_W'($urandom_range(0, 1));
        else ch = CH_IN_W'($urandom_range(0, NCH - 1));
        push_sample(ch, draw_sample(ifmt == FMT_RSVD ? FMT_S32 : ifmt));
        n++;
      end
      seg++;
    end
    push_settle();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (job_q.size() != 0 || in_bus.valid || cfg_bus.valid || owed_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d sample beats (%0d with no output) and %0d register writes across %0d settings",
             n_in, n_silent, n_cfg, n_settings);
    $display("%0d interpolated beats checked, %0d mismatches", n_out, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### linear_interp_resampler.f
rtl/core/lirs_pkg.sv
rtl/core/lirs_in_if.sv
rtl/core/lirs_out_if.sv
rtl/core/lirs_cfg_if.sv
rtl/core/lirs_cfg.sv
rtl/core/lirs_ctrl.sv
rtl/core/lirs_dp.sv
rtl/core/linear_interp_resampler.sv
tb/testbench.sv
